/* rtl/core/crpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpc_pkg
// Shared constants, codes and types of the clock second-chance line cache.
// ----------------------------------------------------------------------------
package crpc_pkg;

    localparam int LINES_DEF    = 16;
    localparam int KEY_BITS_DEF = 32;
    localparam int PIN_BITS_DEF = 8;
    localparam int GEN_BITS_DEF = 4;

    // lines_in_use register
    localparam int             CFG_W     = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    localparam int STATUS_W = 2;

    localparam logic FUNC_ACCESS  = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_RELEASED = 2'd1,
        ST_STALE    = 2'd2,
        ST_ZERO     = 2'd3
    } t_status;

endpackage

/* rtl/core/crpc_tag_cam.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpc_tag_cam
// Key store with valid bits and a fully associative compare over the active
// lines. Lowest matching line wins. One key write and one key read port.
// ----------------------------------------------------------------------------
module crpc_tag_cam #(
    parameter int LINES    = crpc_pkg::LINES_DEF,
    parameter int KEY_BITS = crpc_pkg::KEY_BITS_DEF,
    localparam int IDX_W   = $clog2(LINES),
    localparam int CNT_W   = $clog2(LINES + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [CNT_W-1:0]    i_n_act,
    input  logic [KEY_BITS-1:0] i_key,
    output logic                o_hit,
    output logic [IDX_W-1:0]    o_hit_idx,
    output logic [LINES-1:0]    o_valid,
    input  logic [IDX_W-1:0]    i_rd_idx,
    output logic [KEY_BITS-1:0] o_rd_key,
    input  logic                i_wr_en,
    input  logic [IDX_W-1:0]    i_wr_idx,
    input  logic [KEY_BITS-1:0] i_wr_key
);

    logic [KEY_BITS-1:0] r_key [LINES];
    logic [LINES-1:0]    r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_key[i_wr_idx] <= i_wr_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_idx] <= 1'b1;
        end
    end

    // scan from the top so the lowest matching line is left standing
    always_comb begin
        o_hit     = 1'b0;
        o_hit_idx = '0;
        for (int i = LINES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_key[i] == i_key) && (CNT_W'(i) < i_n_act)) begin
                o_hit     = 1'b1;
                o_hit_idx = IDX_W'(i);
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_rd_key = r_key[i_rd_idx];

endmodule

/* rtl/core/clock_refbit_pinned_cache_policy.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_refbit_pinned_cache_policy
// Fully associative line table with clock second-chance replacement and
// per-line pin counts.
// ----------------------------------------------------------------------------
// Usage:
//   Drive an item on i_func / i_lookup_key / i_handle_line /
//   i_handle_generation and raise start; the item is taken at an edge where
//   busy is low. busy stays high until the result is shown. The result sits
//   on the o_ ports for one cycle marked by o_done, and busy is low in that
//   same cycle, so a new item may be started right then.
//   Steps: S_LOOK, S_READ, S_WB; a miss adds S_SWEEP after S_LOOK, where the
//   clock hand visits one line per cycle, at most two rounds of active lines.
//   Pin counts and generations live in a single-port synchronous RAM
//   (registered read), read once and written back at most once per item.
//   i_cfg_we writes lines_in_use; the user must do so only while the block
//   is idle, as the block itself does not enforce it.
//   Synchronous reset clears the valid, reference and pinned bits, the hand
//   and the register (to 16); no clearing pass is run, invalid lines read as
//   zero. o_done has no back-pressure: the receiver must take each result.
// ----------------------------------------------------------------------------
module clock_refbit_pinned_cache_policy #(
    parameter int LINES    = crpc_pkg::LINES_DEF,
    parameter int KEY_BITS = crpc_pkg::KEY_BITS_DEF,
    parameter int PIN_BITS = crpc_pkg::PIN_BITS_DEF,
    parameter int GEN_BITS = crpc_pkg::GEN_BITS_DEF,
    localparam int IDX_W   = $clog2(LINES)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_func,
    input  logic [KEY_BITS-1:0]        i_lookup_key,
    input  logic [IDX_W-1:0]           i_handle_line,
    input  logic [GEN_BITS-1:0]        i_handle_generation,
    input  logic                       i_cfg_we,
    input  logic [crpc_pkg::CFG_W-1:0] i_cfg_wdata,
    output logic                       o_done,
    output logic                       o_hit,
    output logic [IDX_W-1:0]           o_line_index,
    output logic [GEN_BITS-1:0]        o_line_generation,
    output logic                       o_evicted_valid,
    output logic [KEY_BITS-1:0]        o_evicted_key,
    output logic                       o_forced_eviction,
    output logic [PIN_BITS-1:0]        o_pin_count,
    output logic [crpc_pkg::STATUS_W-1:0] o_status
);

    localparam int CNT_W = $clog2(LINES + 1);
    localparam int CW    = (CNT_W > crpc_pkg::CFG_W) ? CNT_W : crpc_pkg::CFG_W;
    localparam int SW    = CNT_W + 1;
    localparam int MW    = GEN_BITS + PIN_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SWEEP,
        S_READ,
        S_WB
    } t_state;

    t_state                   r_state;
    logic [crpc_pkg::CFG_W-1:0] r_cfg;
    logic                     r_func;
    logic [KEY_BITS-1:0]      r_key;
    logic [IDX_W-1:0]         r_hline;
    logic [GEN_BITS-1:0]      r_hgen;
    logic                     r_is_hit;
    logic                     r_in_range;
    logic                     r_below_n;
    logic [IDX_W-1:0]         r_addr;
    logic [IDX_W-1:0]         r_hand;
    logic [IDX_W-1:0]         r_start;
    logic [SW-1:0]            r_cnt;
    logic [LINES-1:0]         r_ref;
    logic [LINES-1:0]         r_pinned;

    logic [MW-1:0]            r_mem [LINES];
    logic [MW-1:0]            r_rdata;

    logic                     r_done;
    logic                     r_hit;
    logic [IDX_W-1:0]         r_line_index;
    logic [GEN_BITS-1:0]      r_line_gen;
    logic                     r_ev_valid;
    logic [KEY_BITS-1:0]      r_ev_key;
    logic                     r_forced;
    logic [PIN_BITS-1:0]      r_pin_count;
    crpc_pkg::t_status        r_status;

    // active line count, clamped to 1..LINES
    logic [CW-1:0]    cfg_x;
    logic [CW-1:0]    n_full;
    logic [CNT_W-1:0] n_act;

    always_comb begin
        cfg_x = CW'(r_cfg);
        if (cfg_x == '0) begin
            n_full = CW'(1);
        end else if (cfg_x > CW'(LINES)) begin
            n_full = CW'(LINES);
        end else begin
            n_full = cfg_x;
        end
    end
    assign n_act = n_full[CNT_W-1:0];

    // tag store
    logic                cam_hit;
    logic [IDX_W-1:0]    cam_hit_idx;
    logic [LINES-1:0]    line_valid;
    logic [KEY_BITS-1:0] cam_rd_key;
    logic                cam_we;

    crpc_tag_cam #(
        .LINES    (LINES),
        .KEY_BITS (KEY_BITS)
    ) u_cam (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_n_act   (n_act),
        .i_key     (r_key),
        .o_hit     (cam_hit),
        .o_hit_idx (cam_hit_idx),
        .o_valid   (line_valid),
        .i_rd_idx  (r_addr),
        .o_rd_key  (cam_rd_key),
        .i_wr_en   (cam_we),
        .i_wr_idx  (r_addr),
        .i_wr_key  (r_key)
    );

    // hand stepping
    logic [CNT_W-1:0] hand_p1;
    logic [IDX_W-1:0] n_hand;
    logic             hand_ok;
    logic [IDX_W-1:0] n_start;
    logic             sw_take;
    logic [SW-1:0]    last_cnt;

    assign hand_p1  = CNT_W'(r_hand) + CNT_W'(1);
    assign n_hand   = (hand_p1 == n_act) ? '0 : hand_p1[IDX_W-1:0];
    assign hand_ok  = CNT_W'(r_hand) < n_act;
    assign n_start  = hand_ok ? r_hand : '0;
    assign sw_take  = !line_valid[r_hand] || (!r_pinned[r_hand] && !r_ref[r_hand]);
    assign last_cnt = {n_act, 1'b0} - SW'(1);

    // release range checks at lookup time
    logic n_in_range;
    logic n_below_n;
    assign n_in_range = CNT_W'(r_hline) < CNT_W'(LINES);
    assign n_below_n  = CNT_W'(r_hline) < n_act;

    // write-back
    logic                rd_valid;
    logic [GEN_BITS-1:0] old_gen;
    logic [PIN_BITS-1:0] old_pins;
    logic                mem_we;
    logic [GEN_BITS-1:0] n_gen;
    logic [PIN_BITS-1:0] n_pins;
    crpc_pkg::t_status   n_status;
    logic                n_ev;
    logic                n_forced;
    logic [KEY_BITS-1:0] n_ev_key;

    assign rd_valid = r_in_range && line_valid[r_addr];
    assign old_gen  = rd_valid ? r_rdata[MW-1:PIN_BITS] : '0;
    assign old_pins = rd_valid ? r_rdata[PIN_BITS-1:0] : '0;

    always_comb begin
        mem_we   = 1'b0;
        n_gen    = old_gen;
        n_pins   = old_pins;
        n_status = crpc_pkg::ST_DONE;
        n_ev     = 1'b0;
        n_forced = 1'b0;
        n_ev_key = '0;
        if (r_func == crpc_pkg::FUNC_ACCESS) begin
            mem_we = 1'b1;
            if (r_is_hit) begin
                // saturate at all ones
                n_pins = (&old_pins) ? old_pins : old_pins + PIN_BITS'(1);
            end else begin
                n_pins = PIN_BITS'(1);
                if (rd_valid) begin
                    n_ev     = 1'b1;
                    n_ev_key = cam_rd_key;
                    n_forced = (old_pins != '0);
                    n_gen    = old_gen + GEN_BITS'(1);
                end
            end
        end else if (!r_below_n || !rd_valid || (old_gen != r_hgen)) begin
            n_status = crpc_pkg::ST_STALE;
        end else if (old_pins == '0) begin
            n_status = crpc_pkg::ST_ZERO;
        end else begin
            mem_we   = 1'b1;
            n_pins   = old_pins - PIN_BITS'(1);
            n_status = crpc_pkg::ST_RELEASED;
        end
    end

    assign cam_we = (r_state == S_WB) && (r_func == crpc_pkg::FUNC_ACCESS) && !r_is_hit;

    // pin/generation RAM, registered read
    always_ff @(posedge i_clk) begin
        if ((r_state == S_WB) && mem_we) begin
            r_mem[r_addr] <= {n_gen, n_pins};
        end
        r_rdata <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= crpc_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && start) begin
            r_func  <= i_func;
            r_key   <= i_lookup_key;
            r_hline <= i_handle_line;
            r_hgen  <= i_handle_generation;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_hand       <= '0;
            r_start      <= '0;
            r_cnt        <= '0;
            r_ref        <= '0;
            r_pinned     <= '0;
            r_addr       <= '0;
            r_is_hit     <= 1'b0;
            r_in_range   <= 1'b0;
            r_below_n    <= 1'b0;
            r_done       <= 1'b0;
            r_hit        <= 1'b0;
            r_line_index <= '0;
            r_line_gen   <= '0;
            r_ev_valid   <= 1'b0;
            r_ev_key     <= '0;
            r_forced     <= 1'b0;
            r_pin_count  <= '0;
            r_status     <= crpc_pkg::ST_DONE;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (r_func == crpc_pkg::FUNC_RELEASE) begin
                        r_is_hit   <= 1'b0;
                        r_in_range <= n_in_range;
                        r_below_n  <= n_below_n;
                        r_addr     <= r_hline;
                        r_state    <= S_READ;
                    end else if (cam_hit) begin
                        r_is_hit   <= 1'b1;
                        r_in_range <= 1'b1;
                        r_below_n  <= 1'b1;
                        r_addr     <= cam_hit_idx;
                        r_state    <= S_READ;
                    end else begin
                        r_is_hit   <= 1'b0;
                        r_in_range <= 1'b1;
                        r_below_n  <= 1'b1;
                        r_hand     <= n_start;
                        r_start    <= n_start;
                        r_cnt      <= '0;
                        r_state    <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (sw_take) begin
                        r_addr  <= r_hand;
                        r_hand  <= n_hand;
                        r_state <= S_READ;
                    end else begin
                        // second chance: clear the bit and move on
                        r_ref[r_hand] <= 1'b0;
                        if (r_cnt == last_cnt) begin
                            // two rounds without a victim: take the start line
                            r_addr  <= r_start;
                            r_hand  <= r_start;
                            r_state <= S_READ;
                        end else begin
                            r_hand <= n_hand;
                            r_cnt  <= r_cnt + SW'(1);
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (r_func == crpc_pkg::FUNC_ACCESS) begin
                        r_ref[r_addr]    <= 1'b1;
                        r_pinned[r_addr] <= 1'b1;
                    end else if (mem_we) begin
                        r_pinned[r_addr] <= (n_pins != '0);
                    end
                    r_done       <= 1'b1;
                    r_hit        <= r_is_hit;
                    r_line_index <= r_addr;
                    r_line_gen   <= n_gen;
                    r_ev_valid   <= n_ev;
                    r_ev_key     <= n_ev_key;
                    r_forced     <= n_forced;
                    r_pin_count  <= n_pins;
                    r_status     <= n_status;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_done            = r_done;
    assign o_hit             = r_hit;
    assign o_line_index      = r_line_index;
    assign o_line_generation = r_line_gen;
    assign o_evicted_valid   = r_ev_valid;
    assign o_evicted_key     = r_ev_key;
    assign o_forced_eviction = r_forced;
    assign o_pin_count       = r_pin_count;
    assign o_status          = r_status;

endmodule

/* rtl/core/crpc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpc_checker
// Port-level checks of the line cache, bound to the top level.
// ----------------------------------------------------------------------------
module crpc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_done,
    input logic                          o_hit,
    input logic                          o_evicted_valid,
    input logic                          o_forced_eviction,
    input logic [crpc_pkg::STATUS_W-1:0] o_status
);

    // an accepted item keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // busy ends exactly with the result strobe
    a_fell_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result");

    // no two results back to back
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two results in consecutive cycles");

    // a hit is an access that displaced nothing
    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_hit) |->
            (o_status == crpc_pkg::ST_DONE) && !o_evicted_valid)
        else $error("hit with eviction or release status");

    // forced eviction only on a real displacement of an access
    a_forced_ev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_forced_eviction) |->
            o_evicted_valid && (o_status == crpc_pkg::ST_DONE))
        else $error("forced eviction without displaced key");

endmodule

bind clock_refbit_pinned_cache_policy crpc_checker u_crpc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_done            (o_done),
    .o_hit             (o_hit),
    .o_evicted_valid   (o_evicted_valid),
    .o_forced_eviction (o_forced_eviction),
    .o_status          (o_status)
);
